// ----- src/palette_table_with_gradient_fill_top_assert.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the palette table with gradient fill
// used by the checker file of the block
// ---------------------------------------------------------------------------
`ifndef PALETTE_TABLE_WITH_GRADIENT_FILL_TOP_ASSERT_SVH
`define PALETTE_TABLE_WITH_GRADIENT_FILL_TOP_ASSERT_SVH

// checked only while out of reset
`define PTGF_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PTGF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ptgf_pkg.sv -----
// ---------------------------------------------------------------------------
// ptgf_pkg
// shared constants and types of the palette table with gradient fill
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptgf_pkg;

    // palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = 8;
    localparam int CH_W          = 8;
    localparam int RGB_W         = 3 * CH_W;
    localparam int SIZE_W        = 9;
    localparam logic [SIZE_W-1:0] ENTRIES_RESET = 9'd256;

    // restoring division takes one quotient bit per step
    localparam int DIV_STEPS = CH_W;

    // commands
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GRAD  = 2'd2;

    // register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_ENTRIES = 1'b0;

    // control of one color channel unit
    typedef struct packed {
        logic load;
        logic div_step;
        logic fill_step;
    } t_chan_ctl;

endpackage

`default_nettype wire

// ----- src/palette_table_with_gradient_fill_top.sv -----
// ---------------------------------------------------------------------------
// palette_table_with_gradient_fill_top
// order: write or rejected command goes straight to done, read passes the read state,
// gradient (d = index_b - index_a): 8 divide steps, then one ram write per entry
// next beat is taken once the result has moved to the output register
// synchronous active-low reset: palette reads as zero, size back to 256
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palette_table_with_gradient_fill_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // input beats
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // index_a [7:0], index_b [15:8], red_a [23:16], green_a [31:24],
    // blue_a [39:32], red_b [47:40], green_b [55:48], blue_b [63:56]
    input  wire logic [63:0] s_axis_tdata,
    // cmd [1:0]
    input  wire logic [1:0]  s_axis_tuser,

    // result beats
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic [23:0]      m_axis_tdata,
    // failed [0]
    output logic [0:0]       m_axis_tuser,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import ptgf_pkg::*;

    // one-hot sequencer
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FILL = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state                 r_state;
    logic [SIZE_W-1:0]      r_entries;
    logic [PALETTE_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]       r_a;
    logic [IDX_W-1:0]       r_d;
    logic [IDX_W-1:0]       r_k;
    logic                   r_rd_hit;
    logic [RGB_W-1:0]       r_res_rgb;
    logic                   r_res_fail;
    logic                   r_m_valid;
    logic [RGB_W-1:0]       r_m_data;
    logic                   r_m_fail;

    logic [CMD_W-1:0]       w_cmd;
    logic [IDX_W-1:0]       w_idx_a;
    logic [IDX_W-1:0]       w_idx_b;
    logic [CH_W-1:0]        w_red_a;
    logic [CH_W-1:0]        w_green_a;
    logic [CH_W-1:0]        w_blue_a;
    logic [CH_W-1:0]        w_red_b;
    logic [CH_W-1:0]        w_green_b;
    logic [CH_W-1:0]        w_blue_b;

    logic                   w_in_acc;
    logic                   w_a_ok;
    logic                   w_grad_ok;
    logic                   w_cfg_wr;
    logic                   w_out_free;

    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [RGB_W-1:0]       w_wdata;
    logic [RGB_W-1:0]       w_rdata;

    t_chan_ctl              w_ctl;
    logic [CH_W-1:0]        w_red_f;
    logic [CH_W-1:0]        w_green_f;
    logic [CH_W-1:0]        w_blue_f;

    // unpack the input beat
    assign w_cmd     = s_axis_tuser;
    assign w_idx_a   = s_axis_tdata[7:0];
    assign w_idx_b   = s_axis_tdata[15:8];
    assign w_red_a   = s_axis_tdata[23:16];
    assign w_green_a = s_axis_tdata[31:24];
    assign w_blue_a  = s_axis_tdata[39:32];
    assign w_red_b   = s_axis_tdata[47:40];
    assign w_green_b = s_axis_tdata[55:48];
    assign w_blue_b  = s_axis_tdata[63:56];

    // one command in flight at a time
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // size above the depth cannot exclude any 8-bit index, so no clamp needed
    assign w_a_ok    = {1'b0, w_idx_a} < r_entries;
    assign w_grad_ok = (w_idx_a < w_idx_b) && ({1'b0, w_idx_b} < r_entries);

    // configuration port, always ready
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRIES);
    assign prdata   = (paddr[2] == REG_ENTRIES) ?
                      {{(APB_DW-SIZE_W){1'b0}}, r_entries} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RESET;
        end else if (w_cfg_wr) begin
            r_entries <= pwdata[SIZE_W-1:0];
        end
    end

    // ram write port: a single write from the input beat, or the fill walk
    always_comb begin
        if (r_state == ST_FILL) begin
            w_we    = 1'b1;
            w_waddr = r_a + r_k;
            w_wdata = {w_red_f, w_green_f, w_blue_f};
        end else begin
            w_we    = w_in_acc && (w_cmd == CMD_WRITE) && w_a_ok;
            w_waddr = w_idx_a;
            w_wdata = {w_red_a, w_green_a, w_blue_a};
        end
    end

    // palette store; the read address follows the input beat so the data
    // of an accepted read is there in the next cycle
    ptgf_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_idx_a),
        .o_rdata (w_rdata)
    );

    // entry valid bits stand in for clearing the ram: cleared by reset and
    // by shrinking the size, set by any write; an invalid entry reads zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int i = 0; i < PALETTE_DEPTH; i++) begin
                if (w_cfg_wr && (SIZE_W'(i) >= pwdata[SIZE_W-1:0])) begin
                    r_valid[i] <= 1'b0;
                end else if (w_we && (w_waddr == IDX_W'(i))) begin
                    r_valid[i] <= 1'b1;
                end
            end
        end
    end

    // channel units: load on an accepted gradient, divide, then step per entry
    assign w_ctl.load      = w_in_acc && (w_cmd == CMD_GRAD) && w_grad_ok;
    assign w_ctl.div_step  = (r_state == ST_DIV);
    assign w_ctl.fill_step = (r_state == ST_FILL);

    ptgf_chan u_chan_red (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_c1    (w_red_a),
        .i_c2    (w_red_b),
        .i_d     (r_d),
        .o_value (w_red_f)
    );

    ptgf_chan u_chan_green (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_c1    (w_green_a),
        .i_c2    (w_green_b),
        .i_d     (r_d),
        .o_value (w_green_f)
    );

    ptgf_chan u_chan_blue (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_c1    (w_blue_a),
        .i_c2    (w_blue_b),
        .i_d     (r_d),
        .o_value (w_blue_f)
    );

    // result moves on when the output register is empty or being drained
    assign w_out_free = !r_m_valid || m_axis_tready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_res_rgb  <= '0;
                        r_res_fail <= 1'b1;
                        r_state    <= ST_DONE;
                        case (w_cmd)
                            CMD_READ: begin
                                if (w_a_ok) begin
                                    r_rd_hit <= r_valid[w_idx_a];
                                    r_state  <= ST_READ;
                                end
                            end
                            CMD_WRITE: begin
                                r_res_fail <= !w_a_ok;
                            end
                            CMD_GRAD: begin
                                if (w_grad_ok) begin
                                    r_a     <= w_idx_a;
                                    r_d     <= w_idx_b - w_idx_a;
                                    r_k     <= '0;
                                    r_state <= ST_DIV;
                                end
                            end
                            default: begin
                                r_res_fail <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_res_rgb  <= r_rd_hit ? w_rdata : '0;
                    r_res_fail <= 1'b0;
                    r_state    <= ST_DONE;
                end
                ST_DIV: begin
                    if (r_k == IDX_W'(DIV_STEPS - 1)) begin
                        r_k     <= '0;
                        r_state <= ST_FILL;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_FILL: begin
                    // entry a+k is written this cycle; the span ends at k = d
                    if (r_k == r_d) begin
                        r_res_fail <= 1'b0;
                        r_state    <= ST_DONE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_m_data <= r_res_rgb;
            r_m_fail <= r_res_fail;
        end
    end

    // stored as red, green, blue from the top; the beat puts red lowest
    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = {r_m_data[CH_W-1:0], r_m_data[2*CH_W-1:CH_W],
                              r_m_data[RGB_W-1:2*CH_W]};
    assign m_axis_tuser[0] = r_m_fail;

endmodule

`default_nettype wire

// ----- src/ptgf_ram.sv -----
// ---------------------------------------------------------------------------
// ptgf_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptgf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/ptgf_chan.sv -----
// ---------------------------------------------------------------------------
// ptgf_chan
// one color channel of the gradient: serial divide, then exact stepping
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptgf_chan (
    input  wire logic                      i_clk,
    input  wire ptgf_pkg::t_chan_ctl       i_ctl,
    input  wire logic [ptgf_pkg::CH_W-1:0] i_c1,
    input  wire logic [ptgf_pkg::CH_W-1:0] i_c2,
    input  wire logic [ptgf_pkg::CH_W-1:0] i_d,
    output logic      [ptgf_pkg::CH_W-1:0] o_value
);

    import ptgf_pkg::*;

    logic              r_dn;
    logic [CH_W-1:0]   r_c1;
    logic [CH_W-1:0]   r_div_q;
    logic [CH_W-1:0]   r_div_r;
    logic [CH_W-1:0]   r_acc_q;
    logic [CH_W-1:0]   r_acc_r;

    logic [CH_W:0]     w_trial;
    logic [CH_W:0]     w_trial_sub;
    logic              w_trial_ge;
    logic [CH_W:0]     w_sum;
    logic [CH_W:0]     w_sum_sub;
    logic              w_wrap;
    logic [CH_W:0]     w_ceil;

    // restoring step: shift in next dividend bit, subtract when it fits
    assign w_trial     = {r_div_r, r_div_q[CH_W-1]};
    assign w_trial_ge  = w_trial >= {1'b0, i_d};
    assign w_trial_sub = w_trial - {1'b0, i_d};

    // k*diff = acc_q*d + acc_r, advanced by diff = div_q*d + div_r
    assign w_sum     = {1'b0, r_acc_r} + {1'b0, r_div_r};
    assign w_wrap    = w_sum >= {1'b0, i_d};
    assign w_sum_sub = w_sum - {1'b0, i_d};

    // falling ramp rounds the magnitude up
    assign w_ceil  = {1'b0, r_acc_q} + {{CH_W{1'b0}}, (r_acc_r != '0)};
    assign o_value = r_dn ? (r_c1 - w_ceil[CH_W-1:0]) : (r_c1 + r_acc_q);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_c1    <= i_c1;
            r_dn    <= i_c2 < i_c1;
            r_div_q <= (i_c2 < i_c1) ? (i_c1 - i_c2) : (i_c2 - i_c1);
            r_div_r <= '0;
            r_acc_q <= '0;
            r_acc_r <= '0;
        end else if (i_ctl.div_step) begin
            r_div_q <= {r_div_q[CH_W-2:0], w_trial_ge};
            r_div_r <= w_trial_ge ? w_trial_sub[CH_W-1:0] : w_trial[CH_W-1:0];
        end else if (i_ctl.fill_step) begin
            r_acc_r <= w_wrap ? w_sum_sub[CH_W-1:0] : w_sum[CH_W-1:0];
            r_acc_q <= r_acc_q + r_div_q + {{(CH_W-1){1'b0}}, w_wrap};
        end
    end

endmodule

`default_nettype wire

// ----- src/ptgf_check.sv -----
// ---------------------------------------------------------------------------
// ptgf_check
// port-level checks of the palette table with gradient fill
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "palette_table_with_gradient_fill_top_assert.svh"

module ptgf_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // a stalled result beat holds
    `PTGF_ASSERT_RST(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result beat changed while stalled")

    // a rejected command never carries color
    `PTGF_ASSERT_RST(a_fail_zero, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 24'd0,
        "failed result with nonzero color")

    // one command at a time: input closes right after a beat
    `PTGF_ASSERT_RST(a_one_in_flight, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
        "second beat taken while a command is in flight")

    // reset empties the output register
    `PTGF_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !m_axis_tvalid,
        "result valid right after reset")

endmodule

bind palette_table_with_gradient_fill_top ptgf_check u_ptgf_check (.*);

`default_nettype wire
